/* rtl/blcr_pkg.sv */
// Shared types and constants for the clipped line rasterizer.
// No dependencies; used by blcr_walk, bresenham_line_clipped_raster and blcr_check.
`default_nettype none

package blcr_pkg;

  localparam int COORD_W     = 6;
  localparam int RGB_W       = 24;
  localparam int ERR_W       = 9;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic [RGB_W-1:0]        rgb_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // Result of one error-term update.
  typedef struct packed {
    err_t err;
    logic step;
  } walk_t;

endpackage

`default_nettype wire

/* rtl/blcr_walk.sv */
// Shared error-term unit: one Bresenham error update per cycle.
// Depends on blcr_pkg.
`default_nettype none

module blcr_walk (
  input  wire blcr_pkg::err_t  err,
  input  wire blcr_pkg::err_t  two_minor,
  input  wire blcr_pkg::err_t  two_diff,
  output blcr_pkg::walk_t      result
);
  import blcr_pkg::*;

  err_t sum;
  err_t sum_adj;

  // two_diff is 2*minor - 2*major, so the stepped value needs one add only.
  assign sum     = err + two_minor;
  assign sum_adj = err + two_diff;

  always_comb begin
    result.step = ~sum[ERR_W-1];
    result.err  = result.step ? sum_adj : sum;
  end

endmodule

`default_nettype wire

/* rtl/bresenham_line_clipped_raster.sv */
// Line rasterizer: one item in, one item out per pixel of the line (1 to 64).
// A command is captured in IDLE, set up in SETUP and walked in RUN, where each
// of its major+1 pixels (major = longer axis span) enters the output register,
// one pixel per cycle through the shared error unit when the output is free.
// The next command is taken while the last pixel still waits at the output.
// Reset (rst, synchronous): idle, output empty, clip_enable cleared.
`default_nettype none

module bresenham_line_clipped_raster #(
  parameter int RASTER_WIDTH  = 64,
  parameter int RASTER_HEIGHT = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // cfg_data: clip_enable
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire                                 cfg_data,
  // s_tdata: x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18],
  //          line_rgb[47:24]
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire [blcr_pkg::IN_TDATA_W-1:0]      s_tdata,
  // m_tdata: pixel_x[5:0], pixel_y[11:6], pixel_rgb[35:12], zero fill[39:36]
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [blcr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // m_tuser: drawn
  output logic                                m_tuser,
  output logic                                m_tlast
);
  import blcr_pkg::*;

  localparam int XLO = RASTER_WIDTH / 4;
  localparam int XHI = 3 * RASTER_WIDTH / 4;
  localparam int YLO = RASTER_HEIGHT / 4;
  localparam int YHI = 3 * RASTER_HEIGHT / 4;

  typedef enum logic [1:0] {IDLE, SETUP, RUN} state_t;

  state_t state;
  logic   clip_enable;

  // Command registers
  coord_t xa, ya, xb, yb;
  rgb_t   rgb;

  // Walk registers
  coord_t mj, mn, cnt;
  err_t   err, two_minor, two_diff;
  logic   steep, down;

  // Output register
  coord_t pix_x, pix_y;
  rgb_t   pix_rgb;

  // Setup logic
  logic             swap;
  coord_t           x0, y0, x1, y1, dx, ady, major, minor;
  logic signed [COORD_W:0] dy;
  logic             steep_s;

  // Run logic
  coord_t cur_x, cur_y;
  logic   in_win;
  logic   load;
  walk_t  walk;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == IDLE);
  assign m_tdata   = {{(OUT_TDATA_W - RGB_W - 2*COORD_W){1'b0}}, pix_rgb, pix_y, pix_x};

  always_comb begin
    swap = xa > xb;
    x0   = swap ? xb : xa;
    y0   = swap ? yb : ya;
    x1   = swap ? xa : xb;
    y1   = swap ? ya : yb;
    dx   = x1 - x0;
    dy   = $signed({1'b0, y1}) - $signed({1'b0, y0});
    ady  = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    steep_s = ady > dx;
    major   = steep_s ? ady : dx;
    minor   = steep_s ? dx : ady;
  end

  blcr_walk u_walk (
    .err       (err),
    .two_minor (two_minor),
    .two_diff  (two_diff),
    .result    (walk)
  );

  always_comb begin
    cur_x  = steep ? mn : mj;
    cur_y  = steep ? mj : mn;
    in_win = (32'(cur_x) >= XLO) && (32'(cur_x) <= XHI) &&
             (32'(cur_y) >= YLO) && (32'(cur_y) <= YHI);
    load   = (state == RUN) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      clip_enable <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        clip_enable <= cfg_data;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= SETUP;
          end
        end
        SETUP: begin
          state <= RUN;
        end
        RUN: begin
          if (load && cnt == '0) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (state == IDLE && s_tvalid) begin
      xa  <= s_tdata[5:0];
      ya  <= s_tdata[11:6];
      xb  <= s_tdata[17:12];
      yb  <= s_tdata[23:18];
      rgb <= s_tdata[47:24];
    end
    if (state == SETUP) begin
      steep     <= steep_s;
      down      <= dy[COORD_W];
      cnt       <= major;
      err       <= -$signed({3'b000, major});
      two_minor <= $signed({2'b00, minor, 1'b0});
      two_diff  <= $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
      // A steep falling line is walked from its lower-y end, which is (x1, y1).
      if (steep_s) begin
        mj <= dy[COORD_W] ? y1 : y0;
        mn <= dy[COORD_W] ? x1 : x0;
      end else begin
        mj <= x0;
        mn <= y0;
      end
    end
    if (load) begin
      pix_x   <= cur_x;
      pix_y   <= cur_y;
      pix_rgb <= rgb;
      m_tuser <= !clip_enable || in_win;
      m_tlast <= (cnt == '0);
      err     <= walk.err;
      mj      <= mj + 1'b1;
      cnt     <= cnt - 1'b1;
      if (walk.step) begin
        mn <= down ? mn - 1'b1 : mn + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/blcr_check.sv */
// Port-level checks for the clipped line rasterizer, bound to its top level.
// Depends on blcr_pkg for the output stream width.
`default_nettype none

module blcr_check (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_tvalid,
  input wire                              s_tready,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [blcr_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input wire                              m_tuser,
  input wire                              m_tlast
);

  // The output register is empty right after reset.
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // A command keeps the block busy through setup and its first pixel.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
    else $error("input ready too soon after a command");

  // A stalled output item holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) &&
      $stable(m_tuser) && $stable(m_tlast))
    else $error("stalled output item changed");

endmodule

bind bresenham_line_clipped_raster blcr_check u_blcr_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
